// ----- src/hpq_pkg.sv -----
// Package for the binary min-heap priority queue.
// Holds the result status codes, the sequencer state type and the result word type.
// No dependencies; imported by every module of the block.
package hpq_pkg;

  localparam int KEY_W = 32;
  localparam int CNT_W = 7;

  // Request kinds as carried on s_tuser
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_FINISH
  } state_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] popped_key;
    status_t                 status;
    logic [CNT_W-1:0]        entry_count;
  } res_t;

endpackage

// ----- src/hpq_mem.sv -----
// Heap key store: one write port and two registered read ports.
// Depends on hpq_pkg for the key width.
module hpq_mem
  import hpq_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [KEY_W-1:0] rdata_a,
  output logic [KEY_W-1:0] rdata_b
);

  logic [KEY_W-1:0] heap_store [DEPTH];

  // Write one entry
  always_ff @(posedge clk) begin
    if (we) begin
      heap_store[waddr] <= wdata;
    end
  end

  // Registered reads
  always_ff @(posedge clk) begin
    rdata_a <= heap_store[raddr_a];
    rdata_b <= heap_store[raddr_b];
  end

endmodule

// ----- src/hpq_ctrl.sv -----
// Sift sequencer: walks the key store one level at a time, a read state then a compare
// state, carrying the moving key in a register (hole method).
// Depends on hpq_pkg and hpq_mem.
module hpq_ctrl
  import hpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [KEY_W-1:0] new_key,
  input  logic             res_ready,
  output res_t             res
);

  localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int PW = AW + 2;

  state_t                  state, state_next;
  logic [CW-1:0]           count, count_next;
  logic [AW-1:0]           pos, pos_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic signed [KEY_W-1:0] popped, popped_next;
  status_t                 status, status_next;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [KEY_W-1:0]        wdata;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic [KEY_W-1:0]        rdata_a, rdata_b;
  logic signed [KEY_W-1:0] rd_a, rd_b;

  logic [AW-1:0]           parent;
  logic [PW-1:0]           lc, rc, cnt_ext;
  logic                    l_ok, r_ok, take_l, take_r;
  logic signed [KEY_W-1:0] min_l;

  hpq_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign rd_a = $signed(rdata_a);
  assign rd_b = $signed(rdata_b);

  // Tree neighbours of the hole
  assign parent  = AW'((pos - AW'(1)) >> 1);
  assign lc      = {1'b0, pos, 1'b1};
  assign rc      = {1'b0, pos, 1'b0} + PW'(2);
  assign cnt_ext = PW'(count);
  assign l_ok    = lc < cnt_ext;
  assign r_ok    = rc < cnt_ext;

  // Descent compare: left child first, right child wins only if strictly smaller
  assign take_l = l_ok && (key > rd_a);
  assign min_l  = take_l ? rd_a : key;
  assign take_r = r_ok && (min_l > rd_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    key    <= key_next;
    popped <= popped_next;
    status <= status_next;
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    pos_next    = pos;
    key_next    = key;
    popped_next = popped;
    status_next = status;
    we          = 1'b0;
    waddr       = pos;
    wdata       = key;
    raddr_a     = parent;
    raddr_b     = parent;
    in_ready    = 1'b0;
    res         = '0;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        raddr_a  = '0;
        raddr_b  = AW'(count - CW'(1));
        if (in_valid) begin
          popped_next = '0;
          status_next = ST_OK;
          if (req_type == REQ_PUSH) begin
            if (count == CW'(HEAP_DEPTH)) begin
              status_next = ST_FULL;
              state_next  = S_FINISH;
            end else begin
              key_next   = $signed(new_key);
              pos_next   = AW'(count);
              count_next = count + CW'(1);
              state_next = S_UP_RD;
            end
          end else begin
            if (count == '0) begin
              status_next = ST_EMPTY;
              state_next  = S_FINISH;
            end else begin
              // root and last entry are read now, land next cycle
              count_next = count - CW'(1);
              state_next = S_POP_LD;
            end
          end
        end
      end

      S_UP_RD: begin
        if (pos == '0) begin
          we         = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        we = 1'b1;
        if (key < rd_a) begin
          // drop the parent into the hole and climb
          wdata      = rdata_a;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_POP_LD: begin
        popped_next = rd_a;
        key_next    = rd_b;
        pos_next    = '0;
        state_next  = (count == '0) ? S_FINISH : S_DN_RD;
      end

      S_DN_RD: begin
        raddr_a    = lc[AW-1:0];
        raddr_b    = rc[AW-1:0];
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        we = 1'b1;
        if (take_r) begin
          wdata      = rdata_b;
          pos_next   = rc[AW-1:0];
          state_next = S_DN_RD;
        end else if (take_l) begin
          wdata      = rdata_a;
          pos_next   = lc[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        // hand the word over once the output register is free
        if (res_ready) begin
          res.valid       = 1'b1;
          res.popped_key  = popped;
          res.status      = status;
          res.entry_count = CNT_W'(count);
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/min_heap_priority_queue.sv -----
// Binary min-heap priority queue. A push climbs through a read state and a compare
// state per level; a pop loads the root and last entry, then descends through a read
// state and a compare state per level. A full push or an empty pop goes straight to
// the finish state. Each level waits on the registered key store read.
// One request in flight; the next can be taken from the cycle after its word reaches
// the output register. Reset (rst, synchronous) empties the heap and clears m_tvalid.
module min_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int HEAP_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] new_key
  input  logic [0:0]  s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] popped_key, [38:32] entry_count, [39] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  res_t res;
  logic res_ready;

  assign res_ready = !m_tvalid || m_tready;

  hpq_ctrl #(
    .HEAP_DEPTH (HEAP_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (s_tuser[0]),
    .new_key   (s_tdata),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load a finished word, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      m_tdata <= {1'b0, res.entry_count, res.popped_key};
      m_tuser <= res.status;
    end
  end

  a_res_slot_free: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (!m_tvalid || m_tready))
    else $error("result produced while output register still occupied");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sequencer ready again straight after taking a request");

  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[38:0] == 39'd0))
    else $error("empty-pop word carries a key or a nonzero count");

  a_full_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |->
      (m_tdata[38:32] == CNT_W'(HEAP_DEPTH) && m_tdata[31:0] == 32'd0))
    else $error("full-push word does not report a full heap");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the min-heap priority queue (min_heap_priority_queue).
// Drives push and pop words under several idle patterns and checks every reply word.
// Depends on hpq_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import hpq_pkg::*;

  localparam int HEAP_DEPTH = 64;

  // One predicted reply word
  typedef struct {
    logic signed [KEY_W-1:0] popped_key;
    status_t                 status;
    logic [CNT_W-1:0]        entry_count;
  } heap_reply_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] new_key
  logic [0:0]  s_tuser;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // [31:0] popped_key, [38:32] entry_count, [39] zero
  logic [1:0]  m_tuser;   // [1:0] status

  // Shadow heap kept by the predictor
  logic signed [KEY_W-1:0] shadow_keys [HEAP_DEPTH];
  int                      shadow_count;
  heap_reply_t             predicted_replies [$];

  int          send_idle_pct;
  int          sink_stall_pct;
  int          error_count;
  int          reply_index;
  heap_reply_t oldest_reply;

  min_heap_priority_queue #(
    .HEAP_DEPTH(HEAP_DEPTH)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  // Swap two shadow slots
  function automatic void swap_keys(input int a, input int b);
    logic signed [KEY_W-1:0] held;
    held           = shadow_keys[a];
    shadow_keys[a] = shadow_keys[b];
    shadow_keys[b] = held;
  endfunction

  // Climb while strictly smaller than the parent
  function automatic void climb_from(input int start);
    int pos;
    int parent;
    pos = start;
    while (pos != 0) begin
      parent = (pos - 1) / 2;
      if (shadow_keys[pos] < shadow_keys[parent]) begin
        swap_keys(pos, parent);
        pos = parent;
      end else begin
        break;
      end
    end
  endfunction

  // Descend towards the strictly smaller child, left child winning a tie
  function automatic void descend_from_root();
    int pos;
    int best;
    int lc;
    int rc;
    pos = 0;
    forever begin
      best = pos;
      lc   = 2 * pos + 1;
      rc   = 2 * pos + 2;
      if (lc < shadow_count && shadow_keys[best] > shadow_keys[lc]) best = lc;
      if (rc < shadow_count && shadow_keys[best] > shadow_keys[rc]) best = rc;
      if (best == pos) break;
      swap_keys(pos, best);
      pos = best;
    end
  endfunction

  // Apply one accepted request to the shadow heap and work out its reply
  function automatic heap_reply_t heap_apply_request(input logic req,
                                                     input logic signed [KEY_W-1:0] key);
    heap_reply_t reply;
    reply.popped_key = '0;
    reply.status     = ST_OK;
    if (req == REQ_PUSH) begin
      if (shadow_count >= HEAP_DEPTH) begin
        reply.status = ST_FULL;
      end else begin
        shadow_keys[shadow_count] = key;
        shadow_count++;
        climb_from(shadow_count - 1);
      end
    end else begin
      if (shadow_count == 0) begin
        reply.status = ST_EMPTY;
      end else begin
        reply.popped_key = shadow_keys[0];
        shadow_count--;
        shadow_keys[0] = shadow_keys[shadow_count];
        descend_from_root();
      end
    end
    reply.entry_count = shadow_count[CNT_W-1:0];
    return reply;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] reply %0d: %s mismatch, got %0h, expected %0h",
             $realtime, reply_index, what, got, want);
    error_count++;
  endtask

  // Send one request word; hold it until accepted, then predict its reply
  task automatic send_request(input logic req, input logic signed [KEY_W-1:0] key);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= key;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_replies.push_back(heap_apply_request(req, key));
  endtask

  // Keys biased towards ties, the extremes and full-range values
  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom_range(0, 15) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7fffffff;
          1:       return 32'sh80000000;
          2:       return 32'sh7ffffffe;
          default: return 32'sh80000001;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Pop on an empty heap, twice
  task automatic test_pop_empty();
    send_request(REQ_POP, 32'sh12345678);
    send_request(REQ_POP, 32'sh0);
  endtask

  // Push the key extremes, duplicates among them, then drain past empty
  task automatic test_extreme_keys();
    send_request(REQ_PUSH, 32'sh0);
    send_request(REQ_PUSH, 32'sh7fffffff);
    send_request(REQ_PUSH, 32'sh80000000);
    send_request(REQ_PUSH, -32'sh1);
    send_request(REQ_PUSH, 32'sh1);
    send_request(REQ_PUSH, 32'sh80000000);
    send_request(REQ_PUSH, 32'sh7fffffff);
    repeat (8) send_request(REQ_POP, 32'shffffffff);
  endtask

  // Equal keys on both the climb and the descent
  task automatic test_equal_keys();
    send_request(REQ_PUSH, 32'sd7);
    send_request(REQ_PUSH, 32'sd7);
    send_request(REQ_PUSH, 32'sd3);
    send_request(REQ_PUSH, 32'sd3);
    repeat (5) send_request(REQ_POP, 32'sd0);
  endtask

  // Fill the heap, push into it while full, then drain past empty
  task automatic test_fill_and_drain();
    repeat (HEAP_DEPTH + 2) send_request(REQ_PUSH, pick_key());
    repeat (HEAP_DEPTH + 1) send_request(REQ_POP, pick_key());
  endtask

  // Random traffic in runs that lean towards filling, draining or neither
  task automatic test_random_traffic(input int items, input int idle_pct,
                                     input int stall_pct);
    int sent;
    int run_len;
    int push_pct;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    sent = 0;
    while (sent < items) begin
      run_len = $urandom_range(20, 80);
      // Trim the last run to the item budget
      if (run_len > items - sent) run_len = items - sent;
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        if ($urandom_range(0, 99) < push_pct) send_request(REQ_PUSH, pick_key());
        else send_request(REQ_POP, pick_key());
      end
      sent += run_len;
    end
    send_idle_pct  = 0;
    sink_stall_pct = 0;
  endtask

  // Receiver: stall at random
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Check every reply word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch("unexpected reply", m_tdata, 64'h0);
      end else begin
        oldest_reply = predicted_replies.pop_front();
        if (m_tdata[31:0] !== oldest_reply.popped_key)
          report_mismatch("popped_key", m_tdata[31:0], oldest_reply.popped_key);
        if (m_tuser !== oldest_reply.status)
          report_mismatch("status", m_tuser, oldest_reply.status);
        if (m_tdata[38:32] !== oldest_reply.entry_count)
          report_mismatch("entry_count", m_tdata[38:32], oldest_reply.entry_count);
      end
      reply_index++;
    end
  end

  // Hard stop if the block hangs
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int drain_cycles;
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= REQ_PUSH;
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    error_count    = 0;
    reply_index    = 0;
    shadow_count   = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_pop_empty();
    test_extreme_keys();
    test_equal_keys();
    test_fill_and_drain();
    test_random_traffic(350, 0, 0);
    test_random_traffic(350, 88, 0);
    test_random_traffic(350, 0, 88);
    test_random_traffic(350, 23, 23);
    s_tvalid <= 1'b0;

    // Wait for the outstanding replies, then let the block settle
    drain_cycles = 0;
    while (predicted_replies.size() != 0 && drain_cycles < 5000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (predicted_replies.size() != 0)
      report_mismatch("missing replies", predicted_replies.size(), 64'h0);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/hpq_pkg.sv
src/hpq_mem.sv
src/hpq_ctrl.sv
src/min_heap_priority_queue.sv
dv/testbench.sv
